>>> rtl/pie_sector_mask_pixel_defines.svh
// Assertion macros shared by the pie-sector mask checker.
`ifndef PIE_SECTOR_MASK_PIXEL_DEFINES_SVH
`define PIE_SECTOR_MASK_PIXEL_DEFINES_SVH

// Check a property on the rising clock, off while reset is high.
`define PSM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock, also while reset is high.
`define PSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/psm_pkg.sv
// Shared constants and types of the pie-sector mask pixel block.
`default_nettype none
package psm_pkg;

   localparam int MaxRadius   = 256;
   localparam int CordicSteps = 20;
   localparam int GuardBits   = 20;
   localparam int AngleFrac   = 16;
   localparam int QuoBits     = 8;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_SWEEP  = 2'd1,
      REG_DEBUG  = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   // atan(2^-i) in degrees, unsigned Q6.16
   localparam logic [21:0] AtanDegQ16 [CordicSteps] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
      22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
      22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
      22'd115,     22'd57,      22'd29,     22'd14,     22'd7
   };

   // one CORDIC/divider pipeline stage
   typedef struct packed {
      logic               valid;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [24:0] z;
      logic        [25:0] rem;
      logic        [17:0] den;
      logic        [7:0]  quo;
      logic               in_circle;
      logic               dx_zero;
      logic               dx_neg;
      logic               dy_zero;
      logic               dy_neg;
   } cordic_stage_type;

endpackage
`default_nettype wire

>>> rtl/pie_sector_mask_pixel.sv
// Top level of the pie-sector mask pixel generator.
//
// Usage:
//   req_* carries one pixel coordinate per transfer (req_valid / req_stall).
//   rsp_* returns covered and alpha for it, in order (rsp_valid / rsp_stall).
//   csr_* writes radius (0), sweep_angle (1) and full_alpha_debug (2);
//   csr_ready is always high. Write only while the pipeline is empty.
// Pipeline: two setup stages (offsets, squares), one load stage, 20 CORDIC
//   stages with the alpha divider running beside the first eight, one angle
//   stage and the output register.
// Throughput: one pixel per cycle while not stalled; every CORDIC
//   iteration has its own stage.
// Stall: the whole pipeline holds while a result waits under rsp_stall;
//   req_stall rises in the same cycle, nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits and sets radius 1,
//   sweep 360, debug 0.
`default_nettype none
module pie_sector_mask_pixel
   import psm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [8:0] req_pixel_x,
   input  wire logic [8:0] req_pixel_y,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_covered,
   output logic [7:0]      rsp_alpha,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data
);

   logic [8:0] radius_ff, sweep_ff;
   logic       debug_ff;
   logic       adv;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 9'd1;
         sweep_ff  <= 9'd360;
         debug_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_RADIUS: radius_ff <= csr_data;
            REG_SWEEP:  sweep_ff  <= csr_data;
            REG_DEBUG:  debug_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // advance whenever the output register is free or being taken
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // stage 0: offsets from center
   logic              s0_valid_ff;
   logic signed [10:0] s0_dx_ff, s0_dy_ff;
   logic [8:0]        s0_r_ff;
   logic [8:0]        r_eff;
   logic signed [10:0] ctr;
   always_comb begin
      r_eff = (radius_ff > 9'(MaxRadius)) ? 9'(MaxRadius) : radius_ff;
      ctr   = signed'({2'b00, r_eff}) - 11'sd1;
   end
   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (adv) s0_valid_ff <= req_valid;
      if (adv) begin
         s0_dx_ff <= signed'({2'b00, req_pixel_x}) - ctr;
         s0_dy_ff <= ctr - signed'({2'b00, req_pixel_y});
         s0_r_ff  <= r_eff;
      end
   end

   // stage 1: squared distance and squared radius
   logic              s1_valid_ff, s1_inside_ff;
   logic [15:0]       s1_d2_ff;
   logic [16:0]       s1_r2_ff;
   logic [7:0]        s1_ax_ff, s1_ay_ff;
   logic              s1_dxz_ff, s1_dxn_ff, s1_dyz_ff, s1_dyn_ff;
   logic signed [21:0] sq_x, sq_y;
   logic [22:0]       d2;
   logic [16:0]       r2;
   logic [10:0]       ax, ay;
   always_comb begin
      sq_x = s0_dx_ff * s0_dx_ff;
      sq_y = s0_dy_ff * s0_dy_ff;
      d2   = 23'(unsigned'(sq_x)) + 23'(unsigned'(sq_y));
      r2   = 17'(s0_r_ff * s0_r_ff);
      ax   = s0_dx_ff[10] ? 11'(-s0_dx_ff) : unsigned'(s0_dx_ff);
      ay   = s0_dy_ff[10] ? 11'(-s0_dy_ff) : unsigned'(s0_dy_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= s0_valid_ff;
      if (adv) begin
         s1_inside_ff <= (r2 != 17'd0) && (d2 < 23'(r2));
         s1_d2_ff     <= d2[15:0];
         s1_r2_ff     <= r2;
         s1_ax_ff     <= ax[7:0];
         s1_ay_ff     <= ay[7:0];
         s1_dxz_ff    <= (s0_dx_ff == 11'sd0);
         s1_dxn_ff    <= s0_dx_ff[10];
         s1_dyz_ff    <= (s0_dy_ff == 11'sd0);
         s1_dyn_ff    <= s0_dy_ff[10];
      end
   end

   // CORDIC pipeline, divider beside the first stages
   cordic_stage_type cs_ff [CordicSteps+1];
   cordic_stage_type cs_in [CordicSteps+1];

   always_comb begin
      cs_in[0].valid     = s1_valid_ff;
      cs_in[0].x         = signed'(32'(s1_ax_ff) << GuardBits);
      cs_in[0].y         = signed'(32'(s1_ay_ff) << GuardBits);
      cs_in[0].z         = 25'sd0;
      // dividend 510*d2 + r2 over 2*r2 gives the rounded falloff
      cs_in[0].rem       = (26'(s1_d2_ff) << 9) - (26'(s1_d2_ff) << 1) + 26'(s1_r2_ff);
      cs_in[0].den       = {s1_r2_ff, 1'b0};
      cs_in[0].quo       = 8'd0;
      cs_in[0].in_circle = s1_inside_ff;
      cs_in[0].dx_zero   = s1_dxz_ff;
      cs_in[0].dx_neg    = s1_dxn_ff;
      cs_in[0].dy_zero   = s1_dyz_ff;
      cs_in[0].dy_neg    = s1_dyn_ff;
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
      logic signed [31:0] sx, sy;
      logic [25:0]        dsh;
      always_comb begin
         // shift toward zero
         sx = cs_ff[i].x[31] ? -((-cs_ff[i].x) >>> i) : (cs_ff[i].x >>> i);
         sy = cs_ff[i].y[31] ? -((-cs_ff[i].y) >>> i) : (cs_ff[i].y >>> i);
         dsh = 26'(cs_ff[i].den) << ((i < QuoBits) ? (QuoBits - 1 - i) : 0);
         cs_in[i+1] = cs_ff[i];
         if (!cs_ff[i].y[31]) begin
            cs_in[i+1].x = cs_ff[i].x + sy;
            cs_in[i+1].y = cs_ff[i].y - sx;
            cs_in[i+1].z = cs_ff[i].z + signed'(25'(AtanDegQ16[i]));
         end else begin
            cs_in[i+1].x = cs_ff[i].x - sy;
            cs_in[i+1].y = cs_ff[i].y + sx;
            cs_in[i+1].z = cs_ff[i].z - signed'(25'(AtanDegQ16[i]));
         end
         // restoring division: a quotient bit in each stage with i below QuoBits
         if (i < QuoBits && cs_ff[i].rem >= dsh) begin
            cs_in[i+1].rem = cs_ff[i].rem - dsh;
            cs_in[i+1].quo = cs_ff[i].quo | (8'd1 << ((i < QuoBits) ? (QuoBits - 1 - i) : 0));
         end
      end
   end

   for (genvar i = 0; i <= CordicSteps; i++) begin : g_cs_reg
      always_ff @(posedge clock) begin
         if (reset) cs_ff[i].valid <= 1'b0;
         else if (adv) cs_ff[i] <= cs_in[i];
      end
   end

   // angle stage: round, fold into quadrant, clamp, compare with sweep
   cordic_stage_type   cl;
   logic signed [24:0] zc;
   logic [8:0]         t;
   logic signed [10:0] ang;
   logic               a_valid_ff, a_cov_ff;
   logic [7:0]         a_quo_ff;
   always_comb begin
      cl  = cs_ff[CordicSteps];
      zc  = cl.z[24] ? 25'sd0 : cl.z;
      t   = cl.dy_zero ? 9'd0 : 9'((unsigned'(zc) + 25'(1 << (AngleFrac - 1))) >> AngleFrac);
      if (cl.dx_zero) begin
         ang = cl.dy_neg ? 11'sd180 : 11'sd0;
      end else begin
         ang = (cl.dx_neg ? 11'sd270 : 11'sd90);
         if ((!cl.dx_neg) == (!cl.dy_neg && !cl.dy_zero))
            ang = ang - signed'({2'b00, t});
         else
            ang = ang + signed'({2'b00, t});
         if (ang < 11'sd0)   ang = 11'sd0;
         if (ang > 11'sd360) ang = 11'sd360;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (adv) a_valid_ff <= cl.valid;
      if (adv) begin
         a_cov_ff <= cl.in_circle && (unsigned'(ang[9:0]) <= 10'(sweep_ff));
         a_quo_ff <= cl.quo;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= a_valid_ff;
      if (adv) begin
         rsp_covered <= a_cov_ff;
         rsp_alpha   <= !a_cov_ff ? 8'd0 : (debug_ff ? 8'd255 : 8'd255 - a_quo_ff);
      end
   end

endmodule
`default_nettype wire

>>> rtl/psm_checker.sv
// Port-level checker for the pie-sector mask pixel block, with its bind.
`default_nettype none
`include "pie_sector_mask_pixel_defines.svh"
module psm_checker
   import psm_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_covered,
   input wire logic [7:0] rsp_alpha
);

   // no result right after reset
   `PSM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result after reset")
   // a waiting result holds the input side
   `PSM_ASSERT(a_backpressure, clock, reset, (rsp_valid && rsp_stall) |-> req_stall, "input not held")
   // an uncovered pixel is transparent
   `PSM_ASSERT(a_clear_alpha, clock, reset, (rsp_valid && !rsp_covered) |-> (rsp_alpha == 8'd0), "alpha on uncovered pixel")
   // a stalled result holds
   `PSM_ASSERT(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_alpha) && $stable(rsp_covered)), "stalled result changed")

endmodule

bind pie_sector_mask_pixel psm_checker u_psm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_covered (rsp_covered),
   .rsp_alpha   (rsp_alpha)
);
`default_nettype wire

>>> verif/pie_sector_mask_pixel_chk.sv
// Checker for the pie-sector mask pixel block: predicts each pixel result and compares.
`default_nettype none
module pie_sector_mask_pixel_chk
   import psm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [8:0] req_pixel_x,
   input  wire logic [8:0] req_pixel_y,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic       rsp_covered,
   input  wire logic [7:0] rsp_alpha,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data,
   output int              mismatch_count,
   output int              pixels_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       covered;
      logic [7:0] alpha;
   } mask_pixel_type;

   // atan(2^-i) in degrees, Q16.16
   localparam longint AtanStep [20] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };

   logic [8:0] cfg_radius;
   logic [8:0] cfg_sweep;
   logic       cfg_full_alpha;
   mask_pixel_type expected_pixels[$];

   // Shift right with rounding toward zero.
   function automatic longint trunc_shift(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   // Clockwise angle from up, whole degrees, clamped to 0..360.
   function automatic int sector_angle(int dx, int dy);
      longint cx, cy, z, sx, sy;
      int base_deg, t, ang;
      if (dx == 0) return (dy >= 0) ? 0 : 180;
      base_deg = (dx > 0) ? 0 : 180;
      t = 0;
      if (dy != 0) begin
         cx = longint'(dx < 0 ? -dx : dx) <<< 20;
         cy = longint'(dy < 0 ? -dy : dy) <<< 20;
         z = 0;
         for (int i = 0; i < 20; i++) begin
            sx = trunc_shift(cx, i);
            sy = trunc_shift(cy, i);
            if (cy >= 0) begin
               cx += sy;
               cy -= sx;
               z  += AtanStep[i];
            end else begin
               cx -= sy;
               cy += sx;
               z  -= AtanStep[i];
            end
         end
         if (z < 0) z = 0;
         t = int'((z + 32768) >>> 16);
      end
      if ((dx > 0) == (dy > 0)) ang = base_deg + 90 - t;
      else ang = base_deg + 90 + t;
      if (ang < 0) ang = 0;
      if (ang > 360) ang = 360;
      return ang;
   endfunction

   function automatic mask_pixel_type shade_pixel(int px, int py);
      mask_pixel_type res;
      int r, dx, dy;
      longint d2, r2;
      res = '0;
      r = int'(cfg_radius);
      if (r > MaxRadius) r = MaxRadius;
      dx = px - (r - 1);
      dy = (r - 1) - py;
      d2 = longint'(dx) * dx + longint'(dy) * dy;
      r2 = longint'(r) * r;
      if (r2 > 0 && d2 < r2 && sector_angle(dx, dy) <= int'(cfg_sweep)) begin
         res.covered = 1'b1;
         if (cfg_full_alpha) res.alpha = 8'd255;
         else res.alpha = 8'(255 - (510 * d2 + r2) / (2 * r2));
      end
      return res;
   endfunction

   // Track register writes, queue predictions, compare results.
   always @(posedge clock) begin
      mask_pixel_type want;
      if (reset) begin
         cfg_radius     = 9'd1;
         cfg_sweep      = 9'd360;
         cfg_full_alpha = 1'b0;
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_RADIUS: cfg_radius     = csr_data;
               REG_SWEEP:  cfg_sweep      = csr_data;
               REG_DEBUG:  cfg_full_alpha = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_pixels.push_back(shade_pixel(int'(req_pixel_x), int'(req_pixel_y)));
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: covered %0d alpha %0d",
                           rsp_covered, rsp_alpha);
            end else begin
               want = expected_pixels.pop_front();
               if (want.covered !== rsp_covered || want.alpha !== rsp_alpha) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected covered %0d alpha %0d, got covered %0d alpha %0d",
                              want.covered, want.alpha, rsp_covered, rsp_alpha);
               end
            end
         end
      end
      pixels_in_flight = expected_pixels.size();
   end
endmodule
`default_nettype wire

>>> verif/pie_sector_mask_pixel_tb.sv
// Testbench top: drives pixels and register writes into the mask block and gives the verdict.
`default_nettype none
module pie_sector_mask_pixel_tb
   import psm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [8:0] req_pixel_x = '0;
   logic [8:0] req_pixel_y = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_covered;
   logic [7:0] rsp_alpha;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_data = '0;
   int         mismatch_count;
   int         pixels_in_flight;
   int         pixels_sent = 0;
   bit         no_idle = 1'b0;

   pie_sector_mask_pixel u_top (.*);
   pie_sector_mask_pixel_chk u_chk (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the result side at random, except in the quiet stretch.
   always @(posedge clock)
      rsp_stall <= (reset || no_idle) ? 1'b0 : ($urandom_range(0, 99) < 29);

   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

   // Send one pixel; hold it until the transfer happens.
   task automatic send_pixel(int px, int py);
      no_idle = (pixels_sent >= 600 && pixels_sent < 850);
      if (!no_idle && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= 9'(px);
      req_pixel_y <= 9'(py);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic write_reg(reg_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 9'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Drain the pipeline before touching registers or finishing.
   task automatic drain(output bit stuck);
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (pixels_in_flight != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      stuck = (pixels_in_flight != 0);
   endtask

   task automatic configure(int radius, int sweep, int debug_on);
      write_reg(REG_RADIUS, radius);
      write_reg(REG_SWEEP, sweep);
      write_reg(REG_DEBUG, debug_on);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random pixels, mostly inside the image of the current radius.
   task automatic random_pixels(int radius, int count);
      int r, side;
      r = (radius > MaxRadius) ? MaxRadius : (radius < 1 ? 1 : radius);
      side = 2 * r - 1;
      repeat (count) begin
         if ($urandom_range(0, 99) < 85)
            send_pixel($urandom_range(0, side - 1), $urandom_range(0, side - 1));
         else
            send_pixel($urandom_range(0, 511), $urandom_range(0, 511));
      end
   endtask

   initial begin
      int phase_radius [8] = '{256, 256, 0, 300, 5, 17, 100, 40};
      int phase_sweep  [8] = '{180, 0, 360, 511, 90, 270, 360, 200};
      int phase_debug  [8] = '{0, 1, 0, 0, 0, 1, 0, 1};
      bit stuck, any_stuck;
      any_stuck = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: radius one, only the center pixel is inside
      send_pixel(0, 0);
      send_pixel(1, 0);
      random_pixels(1, 40);
      drain(stuck);
      any_stuck |= stuck;

      for (int p = 0; p < 8; p++) begin
         configure(phase_radius[p], phase_sweep[p], phase_debug[p]);
         if (p == 0) begin
            // center, axes, diagonals, corners, outside the image
            send_pixel(255, 255); send_pixel(255, 0);   send_pixel(255, 510);
            send_pixel(510, 255); send_pixel(0, 255);   send_pixel(256, 255);
            send_pixel(254, 255); send_pixel(255, 254); send_pixel(255, 256);
            send_pixel(0, 0);     send_pixel(510, 510); send_pixel(0, 510);
            send_pixel(510, 0);   send_pixel(511, 511); send_pixel(511, 0);
            send_pixel(435, 75);  send_pixel(75, 435);  send_pixel(435, 435);
            send_pixel(75, 75);   send_pixel(256, 1);   send_pixel(254, 509);
         end
         random_pixels(phase_radius[p], 185);
         drain(stuck);
         any_stuck |= stuck;
      end

      if (mismatch_count == 0 && !any_stuck)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
